[rtl/core/lde_pkg.sv]
// Shared types and constants for the linked deque with erase.
`default_nettype none

package lde_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int KIND_W         = 3;
    localparam int DATA_W         = 32;
    localparam int STATUS_W       = 2;
    localparam int COUNT_W        = 7;

    typedef enum logic [KIND_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_ERASE      = 3'd4
    } op_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic signed [DATA_W-1:0] value_in;
    } lde_req_t;

    typedef struct packed {
        status_t                  status;
        logic [COUNT_W-1:0]       item_count;
        logic                     is_empty;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
    } lde_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH_FREE,
        S_POP_LINK,
        S_SCAN,
        S_UNLINK,
        S_RELEASE,
        S_LOAD,
        S_FINISH
    } lde_state_t;

    // write enables into the entry store
    typedef struct packed {
        logic val;
        logic nxt;
        logic prv;
    } lde_wr_en_t;

endpackage

`default_nettype wire

[rtl/core/lde_store.sv]
// Entry store: value, next link and previous link memories with a shared read address.
`default_nettype none

module lde_store
    import lde_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int AW        = $clog2(CAPACITY)
)(
    input  logic                  clk,
    input  lde_wr_en_t            wr_en,
    input  logic [AW-1:0]         rd_addr,
    input  logic [AW-1:0]         val_waddr,
    input  logic [VALUE_BITS-1:0] val_wdata,
    input  logic [AW-1:0]         nxt_waddr,
    input  logic [AW-1:0]         nxt_wdata,
    input  logic [AW-1:0]         prv_waddr,
    input  logic [AW-1:0]         prv_wdata,
    output logic [VALUE_BITS-1:0] val_rdata,
    output logic [AW-1:0]         nxt_rdata,
    output logic [AW-1:0]         prv_rdata
);

    logic [VALUE_BITS-1:0] val_mem [CAPACITY];
    logic [AW-1:0]         nxt_mem [CAPACITY];
    logic [AW-1:0]         prv_mem [CAPACITY];

    // read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en.val)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        val_rdata <= val_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en.nxt)
        begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        nxt_rdata <= nxt_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en.prv)
        begin
            prv_mem[prv_waddr] <= prv_wdata;
        end
        prv_rdata <= prv_mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/core/linked_deque_with_erase_unit.sv]
// Top level of the linked deque with erase: sequencer, list registers and result register.
`default_nettype none

// Bounded doubly linked deque of CAPACITY entries. Each request is one operation
// (push back/front, pop back/front, erase first match from the front) and yields
// one response with status, entry count, empty flag and front/back values. One
// request is in work at a time; cmd_stall is low only while the sequencer idles,
// and a finished response waits in its own register so the next request can enter.
// Steps: a push decodes, reads the next free link on slot reuse, and finishes; a
// pop decodes, reads the entry's links, releases it, reloads the new end value if
// entries remain, and finishes; an erase walks from the front, one entry per cycle
// through the link memory up to the entry count, releases an end match like a pop
// and unlinks a middle one first. Refusals and unknown codes finish after decode;
// a request also holds in its last step while the previous response is stalled.
// Released slots go first, then never-used ones, so reset needs no clearing pass.
module linked_deque_with_erase_unit
    import lde_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  lde_req_t cmd,
    output logic     res_valid,
    input  logic     res_stall,
    output lde_rsp_t res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    lde_state_t            state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [AW-1:0]         free_reg, free_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic                  res_valid_reg, res_valid_next;

    logic [AW-1:0]         node_reg, node_next;
    logic [AW-1:0]         link_p_reg, link_p_next;
    logic [AW-1:0]         link_q_reg, link_q_next;
    logic [CW-1:0]         scan_reg, scan_next;
    logic [VALUE_BITS-1:0] front_reg, front_next;
    logic [VALUE_BITS-1:0] back_reg, back_next;
    op_kind_t              kind_reg, kind_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    status_t               status_reg, status_next;
    logic                  side_front_reg, side_front_next;
    logic                  reload_reg, reload_next;
    lde_rsp_t              res_reg, res_next;

    lde_wr_en_t            wr_en;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         val_waddr;
    logic [VALUE_BITS-1:0] val_wdata;
    logic [AW-1:0]         nxt_waddr;
    logic [AW-1:0]         nxt_wdata;
    logic [AW-1:0]         prv_waddr;
    logic [AW-1:0]         prv_wdata;
    logic [VALUE_BITS-1:0] val_rdata;
    logic [AW-1:0]         nxt_rdata;
    logic [AW-1:0]         prv_rdata;

    logic                  cmd_accept;
    logic                  list_empty;
    logic                  chain_avail;
    logic [AW-1:0]         alloc_idx;

    assign cmd_stall   = (state_reg != S_IDLE);
    assign cmd_accept  = cmd_valid && !cmd_stall;
    assign res_valid   = res_valid_reg;
    assign res         = res_reg;

    assign list_empty  = (count_reg == '0);
    // released slots exist whenever more slots were ever taken than are live
    assign chain_avail = (fill_reg != count_reg);
    assign alloc_idx   = chain_avail ? free_reg : fill_reg[AW-1:0];

    lde_store #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .rd_addr   (rd_addr),
        .val_waddr (val_waddr),
        .val_wdata (val_wdata),
        .nxt_waddr (nxt_waddr),
        .nxt_wdata (nxt_wdata),
        .prv_waddr (prv_waddr),
        .prv_wdata (prv_wdata),
        .val_rdata (val_rdata),
        .nxt_rdata (nxt_rdata),
        .prv_rdata (prv_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_next       = free_reg;
        count_next      = count_reg;
        fill_next       = fill_reg;
        res_valid_next  = res_valid_reg;
        node_next       = node_reg;
        link_p_next     = link_p_reg;
        link_q_next     = link_q_reg;
        scan_next       = scan_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        side_front_next = side_front_reg;
        reload_next     = reload_reg;
        res_next        = res_reg;

        wr_en     = '0;
        rd_addr   = node_reg;
        val_waddr = alloc_idx;
        val_wdata = value_reg;
        nxt_waddr = node_reg;
        nxt_wdata = free_reg;
        prv_waddr = alloc_idx;
        prv_wdata = tail_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    kind_next  = cmd.kind;
                    value_next = VALUE_BITS'($unsigned(cmd.value_in));
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next = ST_DONE;
                unique case (kind_reg)
                    OP_PUSH_BACK, OP_PUSH_FRONT:
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            wr_en.val  = 1'b1;
                            val_waddr  = alloc_idx;
                            val_wdata  = value_reg;
                            // read of the next free slot returns in the following cycle
                            rd_addr    = free_reg;
                            count_next = count_reg + 1'b1;
                            if (kind_reg == OP_PUSH_BACK)
                            begin
                                wr_en.prv = 1'b1;
                                prv_waddr = alloc_idx;
                                prv_wdata = tail_reg;
                                wr_en.nxt = !list_empty;
                                nxt_waddr = tail_reg;
                                nxt_wdata = alloc_idx;
                                if (list_empty)
                                begin
                                    head_next  = alloc_idx;
                                    front_next = value_reg;
                                end
                                tail_next = alloc_idx;
                                back_next = value_reg;
                            end
                            else
                            begin
                                wr_en.nxt = 1'b1;
                                nxt_waddr = alloc_idx;
                                nxt_wdata = head_reg;
                                wr_en.prv = !list_empty;
                                prv_waddr = head_reg;
                                prv_wdata = alloc_idx;
                                if (list_empty)
                                begin
                                    tail_next = alloc_idx;
                                    back_next = value_reg;
                                end
                                head_next  = alloc_idx;
                                front_next = value_reg;
                            end
                            if (chain_avail)
                            begin
                                state_next = S_PUSH_FREE;
                            end
                            else
                            begin
                                fill_next  = fill_reg + 1'b1;
                                state_next = S_FINISH;
                            end
                        end
                    end

                    OP_POP_BACK, OP_POP_FRONT:
                    begin
                        if (list_empty)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            node_next  = (kind_reg == OP_POP_FRONT) ? head_reg : tail_reg;
                            rd_addr    = node_next;
                            state_next = S_POP_LINK;
                        end
                    end

                    OP_ERASE:
                    begin
                        if (list_empty)
                        begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            node_next  = head_reg;
                            rd_addr    = head_reg;
                            scan_next  = CW'(1);
                            state_next = S_SCAN;
                        end
                    end

                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_PUSH_FREE:
            begin
                free_next  = nxt_rdata;
                state_next = S_FINISH;
            end

            S_POP_LINK:
            begin
                if (kind_reg == OP_POP_FRONT)
                begin
                    head_next       = nxt_rdata;
                    side_front_next = 1'b1;
                end
                else
                begin
                    tail_next       = prv_rdata;
                    side_front_next = 1'b0;
                end
                reload_next = 1'b1;
                state_next  = S_RELEASE;
            end

            S_SCAN:
            begin
                // read data belongs to node_reg; the next read follows its link
                priority if (val_rdata == value_reg)
                begin
                    if (node_reg == head_reg)
                    begin
                        head_next       = nxt_rdata;
                        side_front_next = 1'b1;
                        reload_next     = 1'b1;
                        state_next      = S_RELEASE;
                    end
                    else if (node_reg == tail_reg)
                    begin
                        tail_next       = prv_rdata;
                        side_front_next = 1'b0;
                        reload_next     = 1'b1;
                        state_next      = S_RELEASE;
                    end
                    else
                    begin
                        link_p_next = prv_rdata;
                        link_q_next = nxt_rdata;
                        reload_next = 1'b0;
                        state_next  = S_UNLINK;
                    end
                end
                else if (scan_reg == count_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FINISH;
                end
                else
                begin
                    node_next = nxt_rdata;
                    rd_addr   = nxt_rdata;
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_UNLINK:
            begin
                wr_en.nxt  = 1'b1;
                nxt_waddr  = link_p_reg;
                nxt_wdata  = link_q_reg;
                wr_en.prv  = 1'b1;
                prv_waddr  = link_q_reg;
                prv_wdata  = link_p_reg;
                state_next = S_RELEASE;
            end

            S_RELEASE:
            begin
                wr_en.nxt  = 1'b1;
                nxt_waddr  = node_reg;
                nxt_wdata  = free_reg;
                free_next  = node_reg;
                count_next = count_reg - 1'b1;
                // fetch the new end value in case it must be refreshed
                rd_addr    = side_front_reg ? head_reg : tail_reg;
                if (reload_reg && (count_reg != CW'(1)))
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_LOAD:
            begin
                if (side_front_reg)
                begin
                    front_next = val_rdata;
                end
                else
                begin
                    back_next = val_rdata;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.status      = status_reg;
                    res_next.item_count  = COUNT_W'(count_reg);
                    res_next.is_empty    = list_empty;
                    res_next.front_value = list_empty ? '0 : DATA_W'(front_reg);
                    res_next.back_value  = list_empty ? '0 : DATA_W'(back_reg);
                    res_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= '0;
            count_reg     <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        link_p_reg     <= link_p_next;
        link_q_reg     <= link_q_next;
        scan_reg       <= scan_next;
        front_reg      <= front_next;
        back_reg       <= back_next;
        kind_reg       <= kind_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        side_front_reg <= side_front_next;
        reload_reg     <= reload_next;
        res_reg        <= res_next;
    end

    a_count_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fill_reg)
        else $error("live entry count exceeds slots ever taken");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("slot fill mark beyond capacity");

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded next cycle");

    a_finish_posts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !(res_valid_reg && res_stall))
        |=> (res_valid_reg && state_reg == S_IDLE))
        else $error("finished request did not post a response");

endmodule

`default_nettype wire
